### src/ple_pkg.sv
package ple_pkg;

  typedef enum logic [2:0] {
    K_INSERT     = 3'd0,
    K_REMOVE     = 3'd1,
    K_GET        = 3'd2,
    K_FIND       = 3'd3,
    K_REMOVE_VAL = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    RD_POS  = 2'd0,
    RD_PREV = 2'd1,
    RD_CUR  = 2'd2,
    RD_NEXT = 2'd3
  } rd_sel_t;

  typedef enum logic [2:0] {
    IDX_HOLD  = 3'd0,
    IDX_COUNT = 3'd1,
    IDX_POS   = 3'd2,
    IDX_ZERO  = 3'd3,
    IDX_INC   = 3'd4,
    IDX_DEC   = 3'd5
  } idx_op_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    logic    wr_word;
    idx_op_t idx_op;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    set_err;
    logic    take_word;
    logic    mark_hit;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  ins_bad;
    logic  idx_bad;
    logic  at_pos;
    logic  scan_end;
    logic  match;
    logic  last;
  } stat_t;

endpackage

### src/ple_datapath.sv
module ple_datapath import ple_pkg::*; #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [2:0]  kind,
  input  logic [6:0]  position,
  input  logic [31:0] word,
  input  cmd_t        cmd,
  output stat_t       stat,
  output logic        done,
  output logic [31:0] out_word,
  output logic [5:0]  out_position,
  output logic        hit,
  output logic        status,
  output logic [6:0]  length
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int PW = (CW > 7) ? CW : 7;

  logic [WORD_BITS-1:0] mem [DEPTH];

  kind_t                kind_r;
  logic [PW-1:0]        pos_r;
  logic [WORD_BITS-1:0] word_r;
  logic [CW-1:0]        count;
  logic [CW-1:0]        idx;
  logic [CW-1:0]        idx_next;
  logic [WORD_BITS-1:0] rd_data;
  logic [WORD_BITS-1:0] res_word;
  logic [CW-1:0]        hit_pos;
  logic                 hit_r;
  logic                 err_r;
  logic [AW-1:0]        rd_addr;
  logic [WORD_BITS-1:0] wr_data;

  always_comb begin
    case (cmd.rd_sel)
      RD_POS:  rd_addr = AW'(pos_r);
      RD_PREV: rd_addr = AW'(idx - CW'(1));
      RD_CUR:  rd_addr = AW'(idx);
      RD_NEXT: rd_addr = AW'(idx + CW'(1));
      default: rd_addr = AW'(idx);
    endcase
  end

  assign wr_data = cmd.wr_word ? word_r : rd_data;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[AW'(idx)] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    case (cmd.idx_op)
      IDX_HOLD:  idx_next = idx;
      IDX_COUNT: idx_next = count;
      IDX_POS:   idx_next = CW'(pos_r);
      IDX_ZERO:  idx_next = '0;
      IDX_INC:   idx_next = idx + CW'(1);
      IDX_DEC:   idx_next = idx - CW'(1);
      default:   idx_next = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
      done  <= 1'b0;
    end else begin
      idx  <= idx_next;
      done <= cmd.emit;
      if (cmd.cnt_inc) begin
        count <= count + CW'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= kind_t'(kind);
      pos_r    <= PW'(position);
      word_r   <= WORD_BITS'(word);
      res_word <= '0;
      hit_r    <= 1'b0;
      hit_pos  <= '0;
      err_r    <= 1'b0;
    end else begin
      if (cmd.set_err) begin
        err_r <= 1'b1;
      end
      if (cmd.take_word) begin
        res_word <= rd_data;
      end
      if (cmd.mark_hit) begin
        hit_r   <= 1'b1;
        hit_pos <= idx;
      end
    end
    if (cmd.emit) begin
      out_word     <= 32'(res_word);
      out_position <= 6'(hit_pos);
      hit          <= hit_r;
      status       <= err_r;
      length       <= 7'(count);
    end
  end

  always_comb begin
    stat.kind     = kind_r;
    stat.ins_bad  = (pos_r > PW'(count)) || (count >= CW'(DEPTH));
    stat.idx_bad  = pos_r >= PW'(count);
    stat.at_pos   = PW'(idx) == pos_r;
    stat.scan_end = idx == count;
    stat.match    = rd_data == word_r;
    stat.last     = ((CW + 1)'(idx) + (CW + 1)'(1)) >= (CW + 1)'(count);
  end

endmodule

### src/ple_ctrl.sv
module ple_ctrl import ple_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_DECODE   = 11'b00000000010,
    S_INS_CHK  = 11'b00000000100,
    S_INS_WR   = 11'b00000001000,
    S_TAKE     = 11'b00000010000,
    S_GET      = 11'b00000100000,
    S_SCAN     = 11'b00001000000,
    S_CMP      = 11'b00010000000,
    S_MOVE_CHK = 11'b00100000000,
    S_MOVE_WR  = 11'b01000000000,
    S_FINISH   = 11'b10000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = state != S_IDLE;

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_CUR;
    cmd.idx_op = IDX_HOLD;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.kind)
          K_INSERT: begin
            if (stat.ins_bad) begin
              cmd.set_err = 1'b1;
              state_next  = S_FINISH;
            end else begin
              cmd.idx_op = IDX_COUNT;
              state_next = S_INS_CHK;
            end
          end
          K_REMOVE, K_GET: begin
            if (stat.idx_bad) begin
              cmd.set_err = 1'b1;
              state_next  = S_FINISH;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_POS;
              state_next = (stat.kind == K_GET) ? S_GET : S_TAKE;
            end
          end
          K_FIND, K_REMOVE_VAL: begin
            cmd.idx_op = IDX_ZERO;
            state_next = S_SCAN;
          end
          default: begin
            cmd.set_err = 1'b1;
            state_next  = S_FINISH;
          end
        endcase
      end
      S_INS_CHK: begin
        if (stat.at_pos) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_word = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_next  = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PREV;
          state_next = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.idx_op = IDX_DEC;
        state_next = S_INS_CHK;
      end
      S_TAKE: begin
        cmd.take_word = 1'b1;
        cmd.idx_op    = IDX_POS;
        state_next    = S_MOVE_CHK;
      end
      S_GET: begin
        cmd.take_word = 1'b1;
        state_next    = S_FINISH;
      end
      S_SCAN: begin
        if (stat.scan_end) begin
          cmd.set_err = 1'b1;
          state_next  = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_CUR;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (stat.match) begin
          cmd.mark_hit = 1'b1;
          if (stat.kind == K_FIND) begin
            state_next = S_FINISH;
          end else begin
            cmd.take_word = 1'b1;
            state_next    = S_MOVE_CHK;
          end
        end else begin
          cmd.idx_op = IDX_INC;
          state_next = S_SCAN;
        end
      end
      S_MOVE_CHK: begin
        if (stat.last) begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEXT;
          state_next = S_MOVE_WR;
        end
      end
      S_MOVE_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.idx_op = IDX_INC;
        state_next = S_MOVE_CHK;
      end
      S_FINISH: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### src/positional_list_engine.sv
// Channel  | Handshake           | Signals
// ---------+---------------------+--------------------------------------------
// request  | start & !busy       | kind, position, word
// result   | done (one cycle)    | out_word, out_position, hit, status, length
//
// One request at a time; busy stays high from the accepting edge until done.
// Insert shifts the entries at and above position up, remove shifts those
// above position down, get reads one entry, find scans from entry 0 to the
// first match, and remove-value scans and then shifts; errors set status.
// Each moved or scanned entry takes a read, then a write or compare, on one port.
// rst clears the count; entries are not cleared. The receiver cannot stall.
module positional_list_engine import ple_pkg::*; #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind,
  input  logic [6:0]  position,
  input  logic [31:0] word,
  output logic        done,
  output logic [31:0] out_word,
  output logic [5:0]  out_position,
  output logic        hit,
  output logic        status,
  output logic [6:0]  length
);

  cmd_t  cmd;
  stat_t stat;

  ple_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  ple_datapath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .kind         (kind),
    .position     (position),
    .word         (word),
    .cmd          (cmd),
    .stat         (stat),
    .done         (done),
    .out_word     (out_word),
    .out_position (out_position),
    .hit          (hit),
    .status       (status),
    .length       (length)
  );

endmodule
